// ===== rtl/gfau_pkg.sv =====
// Shared types, codes and the microcode ROM of the GF(2^8) arithmetic unit.
package gfau_pkg;

    localparam int unsigned PW = 9;                   // polynomial width
    localparam logic [PW-1:0] POLY_RESET = 9'h11B;    // x^8+x^4+x^3+x+1

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_INV = 2'd1;
    localparam logic [1:0] OP_GCD = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef logic [3:0] t_pc;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD_MUL,
        DP_LOAD_INV,
        DP_LOAD_GCD,
        DP_LOAD_DIV,
        DP_MUL_STEP,
        DP_RED_STEP,
        DP_SWAP
    } t_dp_op;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_R1_ZERO,
        C_CAN_REDUCE,
        C_CNT_NOT_LAST
    } t_cond;

    // Result selection
    typedef enum logic [1:0] {
        RES_MUL,
        RES_INV,
        RES_GCD,
        RES_DIV
    } t_res;

    typedef struct packed {
        t_dp_op dp;
        t_cond  cond;
        t_pc    target;
        logic   done;
        t_res   res;
    } t_uword;

    // Sequencer -> datapath
    typedef struct packed {
        t_dp_op dp;
        logic   done;
        t_res   res;
    } t_ctrl;

    // Datapath -> sequencer
    typedef struct packed {
        logic r1_zero;
        logic can_reduce;
        logic cnt_last;
    } t_status;

    // Program labels
    localparam t_pc PC_MUL      = 4'd0;
    localparam t_pc PC_MUL_STEP = 4'd1;
    localparam t_pc PC_MUL_DONE = 4'd2;
    localparam t_pc PC_INV      = 4'd3;
    localparam t_pc PC_INV_TEST = 4'd4;
    localparam t_pc PC_INV_RED  = 4'd5;
    localparam t_pc PC_INV_SWAP = 4'd6;
    localparam t_pc PC_INV_DONE = 4'd7;
    localparam t_pc PC_GCD      = 4'd8;
    localparam t_pc PC_GCD_TEST = 4'd9;
    localparam t_pc PC_GCD_RED  = 4'd10;
    localparam t_pc PC_GCD_SWAP = 4'd11;
    localparam t_pc PC_GCD_DONE = 4'd12;
    localparam t_pc PC_DIV      = 4'd13;
    localparam t_pc PC_DIV_RED  = 4'd14;
    localparam t_pc PC_DIV_DONE = 4'd15;

    function automatic t_uword uw(t_dp_op dp, t_cond cond, t_pc target, logic done,
                                  t_res res);
        t_uword w;
        w.dp     = dp;
        w.cond   = cond;
        w.target = target;
        w.done   = done;
        w.res    = res;
        return w;
    endfunction

    function automatic t_pc entry_pc(logic [1:0] op);
        t_pc pc;
        unique case (op)
            OP_MUL:  pc = PC_MUL;
            OP_INV:  pc = PC_INV;
            OP_GCD:  pc = PC_GCD;
            default: pc = PC_DIV;
        endcase
        return pc;
    endfunction

    function automatic t_uword ucode_word(t_pc pc);
        t_uword w;
        unique case (pc)
            PC_MUL:      w = uw(DP_LOAD_MUL, C_NEVER,        PC_MUL,      1'b0, RES_MUL);
            PC_MUL_STEP: w = uw(DP_MUL_STEP, C_CNT_NOT_LAST, PC_MUL_STEP, 1'b0, RES_MUL);
            PC_MUL_DONE: w = uw(DP_NOP,      C_NEVER,        PC_MUL,      1'b1, RES_MUL);
            PC_INV:      w = uw(DP_LOAD_INV, C_NEVER,        PC_MUL,      1'b0, RES_INV);
            PC_INV_TEST: w = uw(DP_NOP,      C_R1_ZERO,      PC_INV_DONE, 1'b0, RES_INV);
            PC_INV_RED:  w = uw(DP_RED_STEP, C_CAN_REDUCE,   PC_INV_RED,  1'b0, RES_INV);
            PC_INV_SWAP: w = uw(DP_SWAP,     C_ALWAYS,       PC_INV_TEST, 1'b0, RES_INV);
            PC_INV_DONE: w = uw(DP_NOP,      C_NEVER,        PC_MUL,      1'b1, RES_INV);
            PC_GCD:      w = uw(DP_LOAD_GCD, C_NEVER,        PC_MUL,      1'b0, RES_GCD);
            PC_GCD_TEST: w = uw(DP_NOP,      C_R1_ZERO,      PC_GCD_DONE, 1'b0, RES_GCD);
            PC_GCD_RED:  w = uw(DP_RED_STEP, C_CAN_REDUCE,   PC_GCD_RED,  1'b0, RES_GCD);
            PC_GCD_SWAP: w = uw(DP_SWAP,     C_ALWAYS,       PC_GCD_TEST, 1'b0, RES_GCD);
            PC_GCD_DONE: w = uw(DP_NOP,      C_NEVER,        PC_MUL,      1'b1, RES_GCD);
            PC_DIV:      w = uw(DP_LOAD_DIV, C_NEVER,        PC_MUL,      1'b0, RES_DIV);
            PC_DIV_RED:  w = uw(DP_RED_STEP, C_CAN_REDUCE,   PC_DIV_RED,  1'b0, RES_DIV);
            PC_DIV_DONE: w = uw(DP_NOP,      C_NEVER,        PC_MUL,      1'b1, RES_DIV);
            default:     w = uw(DP_NOP,      C_NEVER,        PC_MUL,      1'b1, RES_MUL);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/gfau_datapath.sv =====
// Register file and step logic: xtime multiply, leading-term reduction, swap.
module gfau_datapath (
    input  logic                      i_clk,
    input  logic                      i_accept,
    input  logic [gfau_pkg::PW-1:0]   i_a,
    input  logic [gfau_pkg::PW-1:0]   i_b,
    input  logic [gfau_pkg::PW-1:0]   i_poly,
    input  gfau_pkg::t_ctrl           i_ctrl,
    output gfau_pkg::t_status         o_status,
    output logic [gfau_pkg::PW-1:0]   o_prim,
    output logic [gfau_pkg::PW-1:0]   o_rem,
    output logic                      o_err
);
    import gfau_pkg::*;

    logic [PW-1:0] r_a, r_b;
    logic [PW-1:0] r_r0, r_r1, r_t0, r_t1;
    logic [PW-1:0] n_r0, n_r1, n_t0, n_t1;
    logic [2:0]    r_cnt, n_cnt;
    logic          r_err, n_err;

    logic [3:0]    deg0, deg1, sh;
    logic          can_reduce;
    logic [PW-1:0] r1_sh, t1_sh, xt;

    // Index of highest set bit (0 for zero input; callers check zero separately)
    function automatic logic [3:0] deg9(logic [PW-1:0] p);
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < PW; i++) begin
            if (p[i]) begin
                d = 4'(i);
            end
        end
        return d;
    endfunction

    always_comb begin
        deg0       = deg9(r_r0);
        deg1       = deg9(r_r1);
        can_reduce = (r_r0 != '0) && (r_r1 != '0) && (deg0 >= deg1);
        sh         = deg0 - deg1;
        r1_sh      = r_r1 << sh;
        t1_sh      = r_t1 << sh;
        // xtime on the low byte, reduced by the low byte of the polynomial
        xt         = {1'b0, r_r0[6:0], 1'b0} ^ (r_r0[7] ? {1'b0, i_poly[7:0]} : '0);
    end

    always_comb begin
        n_r0  = r_r0;
        n_r1  = r_r1;
        n_t0  = r_t0;
        n_t1  = r_t1;
        n_cnt = r_cnt;
        n_err = r_err;
        unique case (i_ctrl.dp)
            DP_LOAD_MUL: begin
                n_r0  = {1'b0, r_a[7:0]};
                n_r1  = {1'b0, r_b[7:0]};
                n_t0  = '0;
                n_cnt = 3'd0;
                n_err = 1'b0;
            end
            DP_LOAD_INV: begin
                n_r0  = i_poly;
                n_r1  = {1'b0, r_a[7:0]};
                n_t0  = '0;
                n_t1  = PW'(1);
                n_err = 1'b0;
            end
            DP_LOAD_GCD: begin
                n_r0  = r_a;
                n_r1  = r_b;
                n_t0  = '0;
                n_t1  = PW'(1);
                n_err = 1'b0;
            end
            DP_LOAD_DIV: begin
                n_r0  = r_a;
                n_r1  = r_b;
                n_t0  = '0;
                n_t1  = PW'(1);
                n_err = (r_b == '0);
            end
            DP_MUL_STEP: begin
                if (r_r1[0]) begin
                    n_t0 = r_t0 ^ r_r0;
                end
                n_r0  = xt;
                n_r1  = r_r1 >> 1;
                n_cnt = r_cnt + 3'd1;
            end
            DP_RED_STEP: begin
                // cancel leading term; quotient/cofactor picks up t1 at same shift
                if (can_reduce) begin
                    n_r0 = r_r0 ^ r1_sh;
                    n_t0 = r_t0 ^ t1_sh;
                end
            end
            DP_SWAP: begin
                n_r0 = r_r1;
                n_r1 = r_r0;
                n_t0 = r_t1;
                n_t1 = r_t0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_r0  <= n_r0;
        r_r1  <= n_r1;
        r_t0  <= n_t0;
        r_t1  <= n_t1;
        r_cnt <= n_cnt;
        r_err <= n_err;
    end

    assign o_status.r1_zero    = (r_r1 == '0);
    assign o_status.can_reduce = can_reduce;
    assign o_status.cnt_last   = (r_cnt == 3'd7);

    always_comb begin
        o_prim = '0;
        o_rem  = '0;
        o_err  = 1'b0;
        case (i_ctrl.res)
            RES_MUL, RES_INV: o_prim = r_t0;
            RES_GCD:          o_prim = r_r0;
            default: begin
                o_err = r_err;
                if (!r_err) begin
                    o_prim = r_t0;
                    o_rem  = r_r0;
                end
            end
        endcase
    end

endmodule

// ===== rtl/gfau_sequencer.sv =====
// Microprogram sequencer: step counter, ROM fetch and conditional jumps.
module gfau_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_op,
    input  logic              i_out_free,
    input  gfau_pkg::t_status i_status,
    output gfau_pkg::t_ctrl   o_ctrl,
    output logic              o_ready
);
    import gfau_pkg::*;

    logic   r_busy, n_busy;
    t_pc    r_pc, n_pc;
    t_uword w;
    logic   take;

    always_comb begin
        w = ucode_word(r_pc);
        unique case (w.cond)
            C_ALWAYS:       take = 1'b1;
            C_R1_ZERO:      take = i_status.r1_zero;
            C_CAN_REDUCE:   take = i_status.can_reduce;
            C_CNT_NOT_LAST: take = !i_status.cnt_last;
            default:        take = 1'b0;
        endcase

        n_busy      = r_busy;
        n_pc        = r_pc;
        o_ctrl.dp   = DP_NOP;
        o_ctrl.done = 1'b0;
        o_ctrl.res  = w.res;

        if (!r_busy) begin
            if (i_accept) begin
                n_busy = 1'b1;
                n_pc   = entry_pc(i_op);
            end
        end else if (w.done) begin
            // hold here until the output register can take the result
            if (i_out_free) begin
                o_ctrl.done = 1'b1;
                n_busy      = 1'b0;
            end
        end else begin
            o_ctrl.dp = w.dp;
            n_pc      = take ? w.target : r_pc + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_MUL;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_ready = !r_busy;

endmodule

// ===== rtl/gf256_arithmetic_unit.sv =====
// Top level of the GF(2^8) / GF(2) polynomial arithmetic unit.
// One request at a time: operation in s_tuser, operands in s_tdata, one
// result per request on the master side (quotient/product/inverse/gcd plus
// remainder, and a divide-by-zero flag in m_tuser). A short microprogram
// drives a 4-register datapath. Divide cancels leading terms one at a time;
// gcd and inverse repeat such Euclid divisions, with a swap between them,
// until the remainder is zero. The single reduction unit clears one leading
// term per cycle. The next request is taken as soon as the result sits in
// the output register; a result that is not taken holds the sequencer on its
// final step. The reduction polynomial is to be written over the cfg channel
// only while idle; the block itself does not enforce this. It resets to
// 0x11B. Multiply reduces with its low 8 bits; inverse runs extended Euclid
// on its full 9 bits. Inverse of zero is zero; divide by zero sets the flag
// and zeroes both results.
module gf256_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [8:0] operand_a, [17:9] operand_b, [23:18] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [8:0] primary_result, [17:9] remainder_result
    output logic [0:0]  o_m_tuser,   // [0] divide_error
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data   // reduction_polynomial
);
    import gfau_pkg::*;

    logic          s_accept;
    logic          out_free;
    t_ctrl         ctrl;
    t_status       status;
    logic [PW-1:0] prim, rem;
    logic          err;

    logic [PW-1:0] r_poly;
    logic          r_out_valid;
    logic [PW-1:0] r_out_prim, r_out_rem;
    logic          r_out_err;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_poly <= i_cfg_data;
        end
    end

    gfau_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_op       (i_s_tuser),
        .i_out_free (out_free),
        .i_status   (status),
        .o_ctrl     (ctrl),
        .o_ready    (o_s_tready)
    );

    gfau_datapath u_dp (
        .i_clk    (i_clk),
        .i_accept (s_accept),
        .i_a      (i_s_tdata[8:0]),
        .i_b      (i_s_tdata[17:9]),
        .i_poly   (r_poly),
        .i_ctrl   (ctrl),
        .o_status (status),
        .o_prim   (prim),
        .o_rem    (rem),
        .o_err    (err)
    );

    // output register decouples the result from the next request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.done) begin
            r_out_prim <= prim;
            r_out_rem  <= rem;
            r_out_err  <= err;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {6'd0, r_out_rem, r_out_prim};
    assign o_m_tuser[0] = r_out_err;

    // result only issued into a free output slot
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.done |-> out_free)
        else $error("result issued while output register occupied");

    // a finished result shows up on the master side next cycle
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.done |=> o_m_tvalid)
        else $error("finished result not presented");

    // one request in flight: no second accept right after one
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("request taken while busy");

    // divide by zero yields zero quotient and remainder
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == 24'd0))
        else $error("divide error with nonzero payload");

endmodule

// ===== bench/gf256_arithmetic_unit_check.sv =====
// Checker for the GF(2^8) arithmetic unit: watches the channels, predicts and compares.
`timescale 1ns / 100ps

module gf256_arithmetic_unit_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,   // [8:0] operand_a, [17:9] operand_b, [23:18] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [8:0] primary_result, [17:9] remainder_result
    input  logic [0:0]  i_m_tuser,   // [0] divide_error
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [8:0]  i_cfg_data,
    output int unsigned o_fail_count,
    output int unsigned o_due,
    output int unsigned o_checked
);
    import gfau_pkg::*;

    typedef struct packed {
        logic [PW-1:0] primary;
        logic [PW-1:0] remainder;
        logic          div_error;
    } t_answer;

    t_answer       answers_due[$];
    logic [PW-1:0] field_poly;

    // highest set bit, -1 for zero
    function automatic int poly_order(logic [31:0] p);
        int d;
        d = -1;
        for (int i = 0; i < 32; i++) begin
            if (p[i]) d = i;
        end
        return d;
    endfunction

    function automatic void poly_longdiv(input logic [31:0] num, input logic [31:0] den,
                                         output logic [31:0] quo, output logic [31:0] rest);
        int dd;
        int rd;
        quo = '0;
        dd  = poly_order(den);
        rd  = poly_order(num);
        while (rd >= dd && rd >= 0 && dd >= 0) begin
            quo[rd-dd] = 1'b1;
            num        = num ^ (den << (rd - dd));
            rd         = poly_order(num);
        end
        rest = num;
    endfunction

    // extended Euclid; coef is the Bezout coefficient of y, kept to 16 bits
    function automatic void euclid(input logic [31:0] x, input logic [31:0] y,
                                   output logic [31:0] g, output logic [31:0] coef);
        logic [31:0] old_r, r, old_t, t, q, rem, prod, tmp;
        old_r = x;
        r     = y;
        old_t = '0;
        t     = 32'd1;
        while (r != 0) begin
            poly_longdiv(old_r, r, q, rem);
            old_r = r;
            r     = rem;
            prod  = '0;
            for (int i = 0; i < 16; i++) begin
                if (t[i]) prod ^= (q & 32'hFFFF) << i;
            end
            tmp   = t;
            t     = (old_t ^ prod) & 32'hFFFF;
            old_t = tmp;
        end
        g    = old_r;
        coef = old_t;
    endfunction

    function automatic t_answer gf_evaluate(logic [1:0] op, logic [PW-1:0] a, logic [PW-1:0] b,
                                            logic [PW-1:0] poly);
        t_answer     ans;
        logic [7:0]  x;
        logic [7:0]  acc;
        logic [31:0] g, coef, q, rest;
        ans = '0;
        case (op)
            OP_MUL: begin
                // xtime loop, reduction by the low byte of the polynomial
                x   = a[7:0];
                acc = '0;
                for (int i = 0; i < 8; i++) begin
                    if (b[i]) acc ^= x;
                    if (x[7]) x = {x[6:0], 1'b0} ^ poly[7:0];
                    else      x = {x[6:0], 1'b0};
                end
                ans.primary = {1'b0, acc};
            end
            OP_INV: begin
                euclid({23'b0, poly}, {24'b0, a[7:0]}, g, coef);
                ans.primary = coef[PW-1:0];
            end
            OP_GCD: begin
                euclid({23'b0, a}, {23'b0, b}, g, coef);
                ans.primary = g[PW-1:0];
            end
            default: begin
                if (b == '0) begin
                    ans.div_error = 1'b1;
                end else begin
                    poly_longdiv({23'b0, a}, {23'b0, b}, q, rest);
                    ans.primary   = q[PW-1:0];
                    ans.remainder = rest[PW-1:0];
                end
            end
        endcase
        return ans;
    endfunction

    initial begin
        o_fail_count = 0;
        o_due        = 0;
        o_checked    = 0;
        field_poly   = POLY_RESET;
    end

    always @(posedge i_clk) begin : watch
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            field_poly = POLY_RESET;
            answers_due.delete();
        end else begin
            // results first: one arriving now belongs to an earlier request
            if (i_m_tvalid && i_m_tready) begin
                got.primary   = i_m_tdata[8:0];
                got.remainder = i_m_tdata[17:9];
                got.div_error = i_m_tuser[0];
                o_checked++;
                if (answers_due.size() == 0) begin
                    $error("result with no request outstanding: primary %h remainder %h err %b",
                           got.primary, got.remainder, got.div_error);
                    o_fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (got.primary !== want.primary) begin
                        $error("primary_result: expected %h, actual %h", want.primary,
                               got.primary);
                        o_fail_count++;
                    end
                    if (got.remainder !== want.remainder) begin
                        $error("remainder_result: expected %h, actual %h", want.remainder,
                               got.remainder);
                        o_fail_count++;
                    end
                    if (got.div_error !== want.div_error) begin
                        $error("divide_error: expected %b, actual %b", want.div_error,
                               got.div_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                answers_due.push_back(gf_evaluate(i_s_tuser, i_s_tdata[8:0], i_s_tdata[17:9],
                                                  field_poly));
            if (i_cfg_valid && i_cfg_ready)
                field_poly = i_cfg_data;
        end
        o_due = answers_due.size();
    end

endmodule

// ===== bench/gf256_arithmetic_unit_test.sv =====
// Top of the GF(2^8) arithmetic unit bench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module gf256_arithmetic_unit_test;
    import gfau_pkg::*;

    // no request moving for this many cycles means the block is hung
    localparam int unsigned HANG_CYCLES = 3000;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned PHASE_ITEMS = 183;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;    // [8:0] operand_a, [17:9] operand_b, [23:18] zero
    logic [1:0]  i_s_tuser;    // [1:0] operation
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;    // [8:0] primary_result, [17:9] remainder_result
    logic [0:0]  o_m_tuser;    // [0] divide_error
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data;

    int unsigned fail_count;
    int unsigned due;
    int unsigned checked;

    int unsigned burst_left = 0;
    int unsigned op_count[4];
    int unsigned poly_writes = 0;
    int unsigned quiet_cycles = 0;

    // receiver pattern state
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;

    gf256_arithmetic_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    gf256_arithmetic_unit_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_due        (due),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side stalls on its own pattern: stretches of always-ready,
    // coin-flip ready, hard stalls and a one-in-three duty cycle.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(4, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= 1'($urandom_range(0, 1));
            2:       i_m_tready <= 1'b0;
            default: i_m_tready <= (rx_left % 3 == 0);
        endcase
    end

    // Hang watchdog: counts cycles in which no channel moves a request.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_CYCLES) begin
            $display("hang: nothing accepted for %0d cycles, %0d results outstanding",
                     quiet_cycles, due);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Sends one request. Called and returns at a falling edge. The sender runs
    // in bursts; a fresh burst may open with a gap, which lands anywhere in the
    // block's multi-cycle work. Zero-length gaps give back-to-back stretches.
    task automatic issue(logic [1:0] op, logic [8:0] a, logic [8:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {6'b0, b, a};
        do @(posedge i_clk); while (!o_s_tready);
        op_count[op]++;
        @(negedge i_clk);
    endtask

    // Holds the sender until every request's result has come back and the
    // block has had time to settle.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (due != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_poly(logic [8:0] p);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= p;
        do @(posedge i_clk); while (!o_cfg_ready);
        poly_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Operands weighted toward the interesting corners: zero, all ones,
    // single terms and low degrees, plus plenty of full-width noise.
    function automatic logic [8:0] pick_operand();
        logic [8:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = 9'h1FF;
            2:       v = 9'($urandom_range(1, 15));
            3:       v = 9'(1) << $urandom_range(0, 8);
            default: v = 9'($urandom_range(0, 511));
        endcase
        return v;
    endfunction

    task automatic random_phase(int unsigned n);
        int unsigned pause_at;
        logic [1:0]  op;
        pause_at = $urandom_range(20, n - 20);
        for (int unsigned i = 0; i < n; i++) begin
            if (i == pause_at) drain();
            op = 2'($urandom_range(0, 3));
            issue(op, pick_operand(), pick_operand());
        end
    endtask

    initial begin
        logic [8:0] poly_set[5];
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = OP_MUL;
        i_cfg_valid = 1'b0;
        i_cfg_data  = POLY_RESET;
        foreach (op_count[k]) op_count[k] = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners under the reset polynomial
        issue(OP_MUL, 9'h1FF, 9'h1FF);     // bit 8 of both operands dropped
        issue(OP_MUL, 9'h053, 9'h0CA);     // AES inverse pair, product is one
        issue(OP_MUL, 9'h000, 9'h0FF);
        issue(OP_MUL, 9'h0FF, 9'h0FF);
        issue(OP_MUL, 9'h080, 9'h002);     // single xtime reduction
        issue(OP_INV, 9'h000, 9'h1FF);     // inverse of zero
        issue(OP_INV, 9'h001, 9'h000);
        issue(OP_INV, 9'h053, 9'h155);
        issue(OP_INV, 9'h1FF, 9'h0AA);     // bit 8 ignored, b unused
        issue(OP_INV, 9'h100, 9'h1FF);     // low byte zero
        issue(OP_GCD, 9'h000, 9'h000);
        issue(OP_GCD, 9'h1FF, 9'h000);
        issue(OP_GCD, 9'h000, 9'h1FF);
        issue(OP_GCD, 9'h1FF, 9'h1FF);
        issue(OP_GCD, 9'h1FF, 9'h100);
        issue(OP_GCD, 9'h006, 9'h00A);
        issue(OP_DIV, 9'h1FF, 9'h000);     // zero divisor
        issue(OP_DIV, 9'h000, 9'h000);
        issue(OP_DIV, 9'h000, 9'h1FF);
        issue(OP_DIV, 9'h1FF, 9'h001);
        issue(OP_DIV, 9'h1FF, 9'h1FF);
        issue(OP_DIV, 9'h005, 9'h100);     // divisor of higher degree
        issue(OP_DIV, 9'h100, 9'h003);
        random_phase(PHASE_ITEMS);

        // extremes of the register range, a common alternative and a random one,
        // then back to the standard field polynomial
        poly_set = '{9'h11D, 9'h100, 9'h1FF, 9'($urandom_range(256, 511)), POLY_RESET};
        foreach (poly_set[k]) begin
            write_poly(poly_set[k]);
            random_phase(PHASE_ITEMS);
        end

        drain();
        $display("covered %0d requests (mul %0d, inv %0d, gcd %0d, div %0d), %0d results",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[OP_MUL],
                 op_count[OP_INV], op_count[OP_GCD], op_count[OP_DIV], checked);
        $display("reduction polynomial rewritten %0d times, %0d mismatches", poly_writes,
                 fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
